FILE: rtl/pfs_pkg.sv
// Shared types and constants for the priority feedback scheduler.
package pfs_pkg;

    localparam logic [2:0] ST_FREE     = 3'd0;
    localparam logic [2:0] ST_DYING    = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_BLOCKED  = 3'd4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_RUNS   = 2'd2;
    localparam logic [1:0] REG_LOWEST = 2'd3;

    localparam logic CMD_STATUS = 1'b0;
    localparam logic CMD_YIELD  = 1'b1;

    // One table entry: status, level, run count.
    typedef struct packed {
        logic [2:0] status;
        logic [2:0] level;
        logic [3:0] runs;
    } slot_entry_t;

endpackage

FILE: rtl/priority_feedback_scheduler.sv
// Priority feedback scheduler: slot table in one memory, scan-based pick.
//
// A status write to a slot in the table reads it, writes it back, then gives
// its result. A yield scans all slots with one table read per cycle, drains
// the read pipeline and, when a slot is picked, reads the current slot and
// writes it back if it was running, then reads and writes back the picked
// slot. A boost bumps an epoch counter and entries with an older epoch read
// as level 0, run count 0; every yield scan writes such entries back with
// the current epoch, so no entry is ever more than one epoch old. After
// reset a clearing pass writes every entry to free before the first item
// is accepted. One item is worked on at a time; its result moves into an
// output register, so the next item can be accepted while the result
// waits. A finished item waits for that register to free.
module priority_feedback_scheduler #(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [5:0]  slot,
    input  logic [2:0]  status,
    input  logic        fresh,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        chosen,
    output logic [5:0]  chosen_slot,
    output logic [2:0]  chosen_level,
    output logic        boosted,
    output logic        idle
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = 8;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    typedef struct packed {
        pfs_pkg::slot_entry_t e;
        logic [EW-1:0]        epoch;
    } mem_word_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRD, S_WWR, S_SCAN, S_CURRD, S_CURWR,
        S_PKRD, S_PKWR, S_DONE
    } state_t;

    mem_word_t mem [SLOTS];
    mem_word_t rd_q;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    mem_word_t     wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    state_t state_reg, state_next;
    logic        mode_reg;
    logic [15:0] period_reg;
    logic [3:0]  rpl_reg;
    logic [2:0]  lowest_reg;
    logic [15:0] ycnt_reg, ycnt_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic        curv_reg, curv_next;
    logic [EW-1:0] epoch_reg, epoch_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic        rdv_reg, rdv_next;
    logic [AW-1:0] rdi_reg, rdi_next;
    logic        found_reg, found_next;
    logic [AW-1:0] pick_reg, pick_next;
    logic [3:0]  best_reg, best_next;
    logic        active_reg, active_next;
    logic        curun_reg, curun_next;
    logic        boost_reg, boost_next;
    logic [5:0]  slot_reg;
    logic [2:0]  status_reg;
    logic        fresh_reg;
    logic        ov_reg, ov_next;
    logic        och_reg, och_next;
    logic [5:0]  osl_reg, osl_next;
    logic [2:0]  olv_reg, olv_next;
    logic        obs_reg, obs_next;
    logic        oid_reg, oid_next;
    logic        out_ch_reg, out_ch_next;
    logic [5:0]  out_sl_reg, out_sl_next;
    logic [2:0]  out_lv_reg, out_lv_next;
    logic        out_bs_reg, out_bs_next;
    logic        out_id_reg, out_id_next;

    pfs_pkg::slot_entry_t rd_e;
    logic [15:0] period_eff;
    logic [15:0] ycnt_inc;
    logic        in_fire;

    always_comb
    begin
        rd_e = rd_q.e;
        if (rd_q.epoch != epoch_reg)
        begin
            rd_e.level = 3'd0;
            rd_e.runs  = 4'd0;
        end
    end

    assign period_eff = (period_reg == 16'd0) ? 16'd1 : period_reg;
    assign ycnt_inc   = ycnt_reg + 16'd1;
    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b1;
            period_reg <= 16'd24;
            rpl_reg    <= 4'd3;
            lowest_reg <= 3'd6;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pfs_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                pfs_pkg::REG_PERIOD: period_reg <= cfg_data;
                pfs_pkg::REG_RUNS:   rpl_reg    <= cfg_data[3:0];
                pfs_pkg::REG_LOWEST: lowest_reg <= cfg_data[2:0];
                default:             mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot_reg   <= slot;
            status_reg <= status;
            fresh_reg  <= fresh;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ycnt_next   = ycnt_reg;
        cur_next    = cur_reg;
        curv_next   = curv_reg;
        epoch_next  = epoch_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        rdv_next    = 1'b0;
        rdi_next    = idx_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        best_next   = best_reg;
        active_next = active_reg;
        curun_next  = curun_reg;
        boost_next  = boost_reg;
        ov_next     = ov_reg && !out_ready;
        och_next    = och_reg;
        osl_next    = osl_reg;
        olv_next    = olv_reg;
        obs_next    = obs_reg;
        oid_next    = oid_reg;
        out_ch_next = out_ch_reg;
        out_sl_next = out_sl_reg;
        out_lv_next = out_lv_reg;
        out_bs_next = out_bs_reg;
        out_id_next = out_id_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_q;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en           = 1'b1;
                wr_data.e       = '0;
                wr_data.epoch   = epoch_reg;
                idx_next        = idx_reg + AW'(1);
                if (idx_reg == LAST)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == pfs_pkg::CMD_STATUS)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(slot);
                        state_next = (32'(slot) < SLOTS) ? S_WRD : S_DONE;
                        och_next = 1'b0;
                        osl_next = '0;
                        olv_next = '0;
                        obs_next = 1'b0;
                        oid_next = 1'b0;
                    end
                    else
                    begin
                        boost_next = 1'b0;
                        ycnt_next  = ycnt_inc;
                        if (ycnt_inc >= period_eff)
                        begin
                            ycnt_next = '0;
                            if (mode_reg)
                            begin
                                boost_next = 1'b1;
                                epoch_next = epoch_reg + EW'(1);
                            end
                        end
                        idx_next    = curv_reg ? ((cur_reg == LAST) ? '0 :
                                      cur_reg + AW'(1)) : '0;
                        cnt_next    = '0;
                        found_next  = 1'b0;
                        best_next   = 4'd8;
                        active_next = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_WRD:
            begin
                state_next = S_WWR;
            end
            S_WWR:
            begin
                wr_en          = 1'b1;
                wr_addr        = AW'(slot_reg);
                wr_data.e      = rd_e;
                wr_data.e.status = status_reg;
                wr_data.epoch  = epoch_reg;
                if (fresh_reg)
                begin
                    wr_data.e.level = 3'd0;
                    wr_data.e.runs  = 4'd0;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                // Issue one read a cycle, evaluate the previous one.
                if (32'(cnt_reg) < SLOTS)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg;
                    rdv_next = 1'b1;
                    rdi_next = idx_reg;
                    idx_next = (idx_reg == LAST) ? '0 : idx_reg + AW'(1);
                    cnt_next = cnt_reg + CW'(1);
                end
                if (rdv_reg)
                begin
                    // bring an entry from an older epoch up to date
                    if (rd_q.epoch != epoch_reg)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = rdi_reg;
                        wr_data.e     = rd_e;
                        wr_data.epoch = epoch_reg;
                    end
                    if (rd_e.status == pfs_pkg::ST_RUNNABLE ||
                        rd_e.status == pfs_pkg::ST_RUNNING ||
                        rd_e.status == pfs_pkg::ST_DYING)
                    begin
                        active_next = 1'b1;
                    end
                    if (rdi_reg == cur_reg)
                    begin
                        curun_next = (rd_e.status == pfs_pkg::ST_RUNNING);
                    end
                    if (rd_e.status == pfs_pkg::ST_RUNNABLE && !(found_reg &&
                        !mode_reg) && {1'b0, rd_e.level} < best_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = rdi_reg;
                        best_next  = mode_reg ? {1'b0, rd_e.level} : 4'd0;
                    end
                end
                if (!rdv_reg && 32'(cnt_reg) >= SLOTS)
                begin
                    curun_next = curun_reg && curv_reg;
                    if (!found_reg && curv_reg && curun_reg)
                    begin
                        found_next = 1'b1;
                        pick_next  = cur_reg;
                    end
                    state_next = S_CURRD;
                end
            end
            S_CURRD:
            begin
                if (!found_reg)
                begin
                    curv_next = 1'b0;
                    och_next  = 1'b0;
                    osl_next  = '0;
                    olv_next  = '0;
                    obs_next  = boost_reg;
                    oid_next  = !active_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = cur_reg;
                    state_next = S_CURWR;
                end
            end
            S_CURWR:
            begin
                if (curun_reg && cur_reg != pick_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cur_reg;
                    wr_data.e = rd_e;
                    wr_data.e.status = pfs_pkg::ST_RUNNABLE;
                    wr_data.epoch = epoch_reg;
                end
                state_next = S_PKRD;
            end
            S_PKRD:
            begin
                rd_en   = 1'b1;
                rd_addr = pick_reg;
                state_next = S_PKWR;
            end
            S_PKWR:
            begin
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data.e = rd_e;
                wr_data.epoch = epoch_reg;
                if (mode_reg)
                begin
                    if (rd_e.runs >= rpl_reg)
                    begin
                        wr_data.e.runs = 4'd0;
                        if (rd_e.level < lowest_reg)
                        begin
                            wr_data.e.level = rd_e.level + 3'd1;
                        end
                    end
                    else
                    begin
                        wr_data.e.runs = rd_e.runs + 4'd1;
                    end
                end
                wr_data.e.status = pfs_pkg::ST_RUNNING;
                cur_next  = pick_reg;
                curv_next = 1'b1;
                och_next  = 1'b1;
                osl_next  = 6'(pick_reg);
                olv_next  = wr_data.e.level;
                obs_next  = boost_reg;
                oid_next  = 1'b0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold the finished item until the output register is free
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    out_ch_next = och_reg;
                    out_sl_next = osl_reg;
                    out_lv_next = olv_reg;
                    out_bs_next = obs_reg;
                    out_id_next = oid_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ycnt_reg   <= '0;
            cur_reg    <= '0;
            curv_reg   <= 1'b0;
            epoch_reg  <= '0;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            rdv_reg    <= 1'b0;
            rdi_reg    <= '0;
            found_reg  <= 1'b0;
            pick_reg   <= '0;
            best_reg   <= 4'd8;
            active_reg <= 1'b0;
            curun_reg  <= 1'b0;
            boost_reg  <= 1'b0;
            ov_reg     <= 1'b0;
            och_reg    <= 1'b0;
            osl_reg    <= '0;
            olv_reg    <= '0;
            obs_reg    <= 1'b0;
            oid_reg    <= 1'b0;
            out_ch_reg <= 1'b0;
            out_sl_reg <= '0;
            out_lv_reg <= '0;
            out_bs_reg <= 1'b0;
            out_id_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ycnt_reg   <= ycnt_next;
            cur_reg    <= cur_next;
            curv_reg   <= curv_next;
            epoch_reg  <= epoch_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            rdv_reg    <= rdv_next;
            rdi_reg    <= rdi_next;
            found_reg  <= found_next;
            pick_reg   <= pick_next;
            best_reg   <= best_next;
            active_reg <= active_next;
            curun_reg  <= curun_next;
            boost_reg  <= boost_next;
            ov_reg     <= ov_next;
            och_reg    <= och_next;
            osl_reg    <= osl_next;
            olv_reg    <= olv_next;
            obs_reg    <= obs_next;
            oid_reg    <= oid_next;
            out_ch_reg <= out_ch_next;
            out_sl_reg <= out_sl_next;
            out_lv_reg <= out_lv_next;
            out_bs_reg <= out_bs_next;
            out_id_reg <= out_id_next;
        end
    end

    assign out_valid    = ov_reg;
    assign chosen       = out_ch_reg;
    assign chosen_slot  = out_sl_reg;
    assign chosen_level = out_lv_reg;
    assign boosted      = out_bs_reg;
    assign idle         = out_id_reg;

    a_chosen_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(chosen && idle))
        else $error("chosen and idle both set");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid &&
        $stable({chosen, chosen_slot, chosen_level, boosted, idle})))
        else $error("waiting result changed");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("item accepted while busy");
    a_pick_current: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PKWR) |=> (curv_reg && cur_reg == $past(pick_reg)))
        else $error("current slot not updated");

endmodule

FILE: test/tb.sv
// Testbench for the priority feedback scheduler: directed and random commands against a model.
`timescale 1ns / 100ps

module tb;

    localparam int NSLOT     = 64;
    localparam int IDLE_MAX  = 20000;
    localparam int HOLD_LEN  = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        cmd;
    logic [5:0]  slot;
    logic [2:0]  status;
    logic        fresh;
    logic        out_valid;
    logic        out_ready;
    logic        chosen;
    logic [5:0]  chosen_slot;
    logic [2:0]  chosen_level;
    logic        boosted;
    logic        idle;

    typedef struct packed {
        logic       chosen;
        logic [5:0] pick;
        logic [2:0] level;
        logic       boosted;
        logic       idle;
    } pick_t;

    // scheduler model state
    logic [2:0]  m_status [NSLOT];
    logic [2:0]  m_level  [NSLOT];
    logic [3:0]  m_runs   [NSLOT];
    logic [15:0] m_yields;
    logic [5:0]  m_cur;
    logic        m_cur_ok;
    logic        m_mode;
    logic [15:0] m_period;
    logic [3:0]  m_rpl;
    logic [2:0]  m_lowest;

    pick_t picks_due[$];
    int    errors;
    int    n_sent;
    int    n_seen;
    int    quiet;
    int    send_idle;
    int    recv_idle;
    bit    hold_recv;
    int    hold_cnt;

    priority_feedback_scheduler u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic pick_t schedule(logic c, logic [5:0] s, logic [2:0] st, logic f);
        pick_t r;
        int    per;
        int    start;
        int    idx;
        int    best;
        int    pk;
        bit    found;
        bit    cur_run;
        r = '0;
        if (c == pfs_pkg::CMD_STATUS)
        begin
            m_status[s] = st;
            if (f)
            begin
                m_level[s] = '0;
                m_runs[s]  = '0;
            end
            return r;
        end
        per = (m_period == 0) ? 1 : m_period;
        m_yields = m_yields + 16'd1;
        if (m_yields >= per)
        begin
            m_yields = '0;
            if (m_mode)
            begin
                for (int i = 0; i < NSLOT; i++)
                begin
                    m_level[i] = '0;
                    m_runs[i]  = '0;
                end
                r.boosted = 1'b1;
            end
        end
        start = m_cur_ok ? (m_cur + 1) % NSLOT : 0;
        best = 8;
        pk = 0;
        found = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            idx = (start + i) % NSLOT;
            if (m_status[idx] != pfs_pkg::ST_RUNNABLE) continue;
            if (!m_mode)
            begin
                pk = idx;
                found = 1;
                break;
            end
            if (m_level[idx] < best)
            begin
                best = m_level[idx];
                pk = idx;
                found = 1;
            end
        end
        cur_run = m_cur_ok && m_status[m_cur] == pfs_pkg::ST_RUNNING;
        if (!found && cur_run)
        begin
            pk = m_cur;
            found = 1;
        end
        if (found)
        begin
            if (m_mode)
            begin
                if (m_runs[pk] >= m_rpl)
                begin
                    m_runs[pk] = '0;
                    if (m_level[pk] < m_lowest) m_level[pk] = m_level[pk] + 3'd1;
                end
                else
                    m_runs[pk] = m_runs[pk] + 4'd1;
            end
            if (cur_run) m_status[m_cur] = pfs_pkg::ST_RUNNABLE;
            m_status[pk] = pfs_pkg::ST_RUNNING;
            m_cur = pk;
            m_cur_ok = 1'b1;
            r.chosen = 1'b1;
            r.pick = pk;
            r.level = m_level[pk];
        end
        else
        begin
            m_cur_ok = 1'b0;
            r.idle = 1'b1;
            for (int i = 0; i < NSLOT; i++)
                if (m_status[i] == pfs_pkg::ST_RUNNABLE
                    || m_status[i] == pfs_pkg::ST_RUNNING
                    || m_status[i] == pfs_pkg::ST_DYING)
                    r.idle = 1'b0;
        end
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch on result %0d: %s got %0d want %0d", n_seen, what, got, want);
    endtask

    // valid stays high after an item until the next one or an idle cycle drops it
    task automatic send_item(logic c, logic [5:0] s, logic [2:0] st, logic f);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= c;
        slot <= s;
        status <= st;
        fresh <= f;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        picks_due.push_back(schedule(c, s, st, f));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        in_valid <= 1'b0;
        // let queued work drain before touching a register
        while (picks_due.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            pfs_pkg::REG_MODE:   m_mode   = val[0];
            pfs_pkg::REG_PERIOD: m_period = val;
            pfs_pkg::REG_RUNS:   m_rpl    = val[3:0];
            default:             m_lowest = val[2:0];
        endcase
    endtask

    task automatic setup(logic md, logic [15:0] per, logic [3:0] rpl, logic [2:0] low);
        write_reg(pfs_pkg::REG_MODE, 16'(md));
        write_reg(pfs_pkg::REG_PERIOD, per);
        write_reg(pfs_pkg::REG_RUNS, 16'(rpl));
        write_reg(pfs_pkg::REG_LOWEST, 16'(low));
    endtask

    task automatic yield_item();
        send_item(pfs_pkg::CMD_YIELD, 6'($urandom), 3'($urandom), 1'($urandom));
    endtask

    task automatic test_directed();
        yield_item();
        send_item(pfs_pkg::CMD_STATUS, 6'd63, pfs_pkg::ST_RUNNABLE, 1'b1);
        send_item(pfs_pkg::CMD_STATUS, 6'd0, pfs_pkg::ST_RUNNABLE, 1'b0);
        send_item(pfs_pkg::CMD_STATUS, 6'd5, pfs_pkg::ST_DYING, 1'b0);
        repeat (6) yield_item();
        send_item(pfs_pkg::CMD_STATUS, 6'd63, 3'd7, 1'b1);
        send_item(pfs_pkg::CMD_STATUS, 6'd0, pfs_pkg::ST_BLOCKED, 1'b0);
        repeat (2) yield_item();
        send_item(pfs_pkg::CMD_STATUS, 6'd5, pfs_pkg::ST_FREE, 1'b1);
        yield_item();
        send_item(pfs_pkg::CMD_STATUS, 6'd20, 3'd5, 1'b0);
        send_item(pfs_pkg::CMD_STATUS, 6'd21, 3'd6, 1'b1);
        send_item(pfs_pkg::CMD_STATUS, 6'd22, pfs_pkg::ST_RUNNING, 1'b0);
        repeat (3) yield_item();
    endtask

    task automatic random_item();
        logic [2:0] st;
        if ($urandom_range(99) < 45)
            yield_item();
        else
        begin
            // mostly runnable so picks stay frequent
            st = ($urandom_range(99) < 60) ? pfs_pkg::ST_RUNNABLE : 3'($urandom);
            send_item(pfs_pkg::CMD_STATUS,
                      $urandom_range(15) == 0 ? 6'($urandom) : 6'($urandom_range(11)),
                      st, 1'($urandom));
        end
    endtask

    task automatic test_random(int count);
        repeat (count) random_item();
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        repeat (20) random_item();
    endtask

    // receiver: check each result against the oldest prediction
    always @(posedge clk)
    begin
        pick_t w;
        if (out_valid && out_ready)
        begin
            n_seen++;
            if (picks_due.size() == 0)
            begin
                errors++;
                $display("result %0d arrived with nothing predicted", n_seen);
            end
            else
            begin
                w = picks_due.pop_front();
                if (chosen !== w.chosen) report("chosen", chosen, w.chosen);
                if (chosen_slot !== w.pick) report("chosen_slot", chosen_slot, w.pick);
                if (chosen_level !== w.level) report("chosen_level", chosen_level, w.level);
                if (boosted !== w.boosted) report("boosted", boosted, w.boosted);
                if (idle !== w.idle) report("idle", idle, w.idle);
            end
        end
    end

    // random readiness, apart from one long hold once requested
    always @(negedge clk)
    begin
        if (hold_recv && hold_cnt < HOLD_LEN)
        begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= IDLE_MAX)
        begin
            $display("timeout with %0d results outstanding", picks_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        slot = '0;
        status = '0;
        fresh = '0;
        out_ready = 1'b0;
        hold_recv = 1'b0;
        hold_cnt = 0;
        errors = 0;
        n_sent = 0;
        n_seen = 0;
        quiet = 0;
        send_idle = 29;
        recv_idle = 73;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_status[i] = '0;
            m_level[i] = '0;
            m_runs[i] = '0;
        end
        m_yields = '0;
        m_cur = '0;
        m_cur_ok = 1'b0;
        m_mode = 1'b1;
        m_period = 16'd24;
        m_rpl = 4'd3;
        m_lowest = 3'd6;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(250);
        test_backpressure();
        setup(1'b0, 16'd1, 4'd15, 3'd7);
        test_random(120);
        send_idle = 73;
        recv_idle = 29;
        setup(1'b1, 16'd1, 4'd1, 3'd1);
        test_random(120);
        setup(1'b1, 16'd65535, 4'd15, 3'd7);
        test_random(120);
        send_idle = 0;
        recv_idle = 0;
        setup(1'b1, 16'd7, 4'd2, 3'd3);
        test_random(100);
        setup(1'b1, 16'd0, 4'd0, 3'd0);
        test_random(100);

        in_valid <= 1'b0;
        while (picks_due.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Sent %0d commands, checked %0d results over six register settings,",
                 n_sent, n_seen);
        $display("round robin and priority modes, with stalls on both sides.");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
